@@ rtl/tcce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text cursor control engine package
// Shared control codes, result actions, register indexes and the stop
// search result type.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Control character codes.
  localparam logic [7:0] CODE_BS = 8'd8;
  localparam logic [7:0] CODE_HT = 8'd9;
  localparam logic [7:0] CODE_LF = 8'd10;
  localparam logic [7:0] CODE_VT = 8'd11;
  localparam logic [7:0] CODE_FF = 8'd12;
  localparam logic [7:0] CODE_CR = 8'd13;

  // Widths fixed by the interface.
  localparam int unsigned CodeW  = 8;
  localparam int unsigned PosW   = 6;
  localparam int unsigned StopsW = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  // What the downstream character store must do.
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_PLACE  = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_COLUMNS_IN_WINDOW = 3'd0,
    REG_WRAP_ON           = 3'd1,
    REG_H_TABS_ON         = 3'd2,
    REG_V_TABS_ON         = 3'd3,
    REG_H_TAB_STOPS       = 3'd4,
    REG_V_TAB_STOPS       = 3'd5,
    REG_DELETED_CODE      = 3'd6
  } reg_index_t;

  // Result of a tab stop search.
  typedef struct packed {
    logic            found;
    logic [PosW-1:0] pos;
  } stop_hit_t;

endpackage : tcce_pkg
`default_nettype wire

@@ rtl/tcce_next_stop.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tab stop search
// Finds the lowest set stop bit above the current position and below LIMIT.
// ----------------------------------------------------------------------------
module tcce_next_stop
  import tcce_pkg::*;
#(
  parameter int unsigned LIMIT = 64
) (
  input  wire logic [StopsW-1:0] stops,
  input  wire logic [PosW-1:0]   pos,
  output stop_hit_t              hit
);

  // Walk from the top down so the lowest qualifying bit is the last one kept.
  always_comb begin
    hit = '0;
    for (int k = StopsW - 1; k >= 0; k--) begin
      if ((k < int'(LIMIT)) && (k > int'(pos)) && stops[k]) begin
        hit.found = 1'b1;
        hit.pos   = PosW'(k);
      end
    end
  end

endmodule : tcce_next_stop
`default_nettype wire

@@ rtl/text_cursor_control_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text cursor control engine
// Tracks a character cursor and turns a character stream into store actions.
// ----------------------------------------------------------------------------
// Each input item carries one character code and a style byte. The block
// keeps the cursor column and row and returns exactly one result item per
// input item: place a glyph, delete a cell, clear the window, or nothing.
// Line feed, carriage return, form feed, backspace, horizontal tab and
// vertical tab move the cursor; the configured deleted code is ignored; any
// other code is placed at the cursor, which then advances and may wrap.
// An item is captured in an input register, decoded against the cursor
// there and written to the result register, so the block takes one item
// every cycle while the output channel does not stall. The combinational
// cursor update, including the 64-bit tab stop priority search, sets that
// rate. Configuration writes are always accepted and take effect on the
// next item that is decoded.
// ----------------------------------------------------------------------------
module text_cursor_control_engine
  import tcce_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,

  // Configuration write channel.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,

  // Character input channel.
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CodeW-1:0]    char_code,
  input  wire logic [CodeW-1:0]    char_style,

  // Store action output channel.
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [1:0]               action,
  output logic [PosW-1:0]          cell_col,
  output logic [PosW-1:0]          cell_row,
  output logic [CodeW-1:0]         glyph_code,
  output logic [CodeW-1:0]         glyph_style
);

  // Limits in the 7-bit domain used for column and row arithmetic.
  localparam logic [PosW:0] MaxCols = (PosW + 1)'(MAX_COLS);
  localparam logic [PosW:0] MaxRows = (PosW + 1)'(MAX_ROWS);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [PosW:0]       columns_in_window;
  logic                wrap_on;
  logic                h_tabs_on;
  logic                v_tabs_on;
  logic [StopsW-1:0]   h_tab_stops;
  logic [StopsW-1:0]   v_tab_stops;
  logic [CodeW-1:0]    deleted_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_window <= 7'd64;
      wrap_on           <= 1'b1;
      h_tabs_on         <= 1'b0;
      v_tabs_on         <= 1'b0;
      h_tab_stops       <= '0;
      v_tab_stops       <= '0;
      deleted_code      <= 8'd127;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COLUMNS_IN_WINDOW: columns_in_window <= cfg_data[PosW:0];
        REG_WRAP_ON:           wrap_on           <= cfg_data[0];
        REG_H_TABS_ON:         h_tabs_on         <= cfg_data[0];
        REG_V_TABS_ON:         v_tabs_on         <= cfg_data[0];
        REG_H_TAB_STOPS:       h_tab_stops       <= cfg_data;
        REG_V_TAB_STOPS:       v_tab_stops       <= cfg_data;
        REG_DELETED_CODE:      deleted_code      <= cfg_data[CodeW-1:0];
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register drains into the result register whenever
  // the result register is empty or its item is being taken this cycle.
  // --------------------------------------------------------------------------
  logic             in_reg_valid;
  logic [CodeW-1:0] in_reg_code;
  logic [CodeW-1:0] in_reg_style;
  logic             advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_code  <= char_code;
      in_reg_style <= char_style;
    end
  end

  // --------------------------------------------------------------------------
  // Cursor state and tab stop search.
  // --------------------------------------------------------------------------
  logic [PosW-1:0] cursor_col;
  logic [PosW-1:0] cursor_row;
  logic [PosW-1:0] cursor_col_next;
  logic [PosW-1:0] cursor_row_next;
  stop_hit_t       h_hit;
  stop_hit_t       v_hit;

  tcce_next_stop #(
    .LIMIT (MAX_COLS)
  ) u_h_stop (
    .stops (h_tab_stops),
    .pos   (cursor_col),
    .hit   (h_hit)
  );

  tcce_next_stop #(
    .LIMIT (MAX_ROWS)
  ) u_v_stop (
    .stops (v_tab_stops),
    .pos   (cursor_row),
    .hit   (v_hit)
  );

  // Row after a line step: saturates at the last row.
  logic [PosW-1:0] row_stepped;
  logic [PosW:0]   row_plus;

  assign row_plus    = {1'b0, cursor_row} + 1'b1;
  assign row_stepped = (row_plus < MaxRows) ? row_plus[PosW-1:0] : cursor_row;

  // Column arithmetic for a placed glyph. An oversized window counts as the
  // full width, and a window of zero columns always wraps when wrapping is on.
  logic [PosW:0] cols_eff;
  logic [PosW:0] col_plus;

  assign cols_eff = (columns_in_window > MaxCols) ? MaxCols : columns_in_window;
  assign col_plus = {1'b0, cursor_col} + 1'b1;

  // --------------------------------------------------------------------------
  // Character decode. Control codes take precedence over the deleted code.
  // --------------------------------------------------------------------------
  action_t         act_next;
  logic [PosW-1:0] cell_col_next;
  logic [PosW-1:0] cell_row_next;
  logic [CodeW-1:0] glyph_code_next;
  logic [CodeW-1:0] glyph_style_next;

  always_comb begin
    cursor_col_next  = cursor_col;
    cursor_row_next  = cursor_row;
    act_next         = ACT_NONE;
    cell_col_next    = '0;
    cell_row_next    = '0;
    glyph_code_next  = '0;
    glyph_style_next = '0;

    unique case (in_reg_code)
      CODE_LF: begin
        cursor_col_next = '0;
        cursor_row_next = row_stepped;
      end
      CODE_HT: begin
        if (h_tabs_on) begin
          if (h_hit.found) begin
            cursor_col_next = h_hit.pos;
          end else begin
            // No stop to the right: behave as a line feed.
            cursor_col_next = '0;
            cursor_row_next = row_stepped;
          end
        end
      end
      CODE_CR: begin
        cursor_col_next = '0;
      end
      CODE_FF: begin
        cursor_col_next = '0;
        cursor_row_next = '0;
        act_next        = ACT_CLEAR;
      end
      CODE_VT: begin
        if (v_tabs_on && v_hit.found) begin
          cursor_row_next = v_hit.pos;
        end
      end
      CODE_BS: begin
        // Step back, stopping at the left edge, then delete the cell there.
        if (cursor_col != '0) begin
          cursor_col_next = cursor_col - 1'b1;
        end
        act_next      = ACT_DELETE;
        cell_col_next = cursor_col_next;
        cell_row_next = cursor_row;
      end
      default: begin
        if (in_reg_code != deleted_code) begin
          act_next         = ACT_PLACE;
          cell_col_next    = cursor_col;
          cell_row_next    = cursor_row;
          glyph_code_next  = in_reg_code;
          glyph_style_next = in_reg_style;
          if (wrap_on && (col_plus >= cols_eff)) begin
            cursor_col_next = '0;
            cursor_row_next = row_stepped;
          end else if (col_plus >= MaxCols) begin
            cursor_col_next = PosW'(MAX_COLS - 1);
          end else begin
            cursor_col_next = col_plus[PosW-1:0];
          end
        end
      end
    endcase
  end

  // The cursor moves only when the decoded item enters the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (in_reg_valid && advance) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_reg_valid && advance) begin
      action      <= act_next;
      cell_col    <= cell_col_next;
      cell_row    <= cell_row_next;
      glyph_code  <= glyph_code_next;
      glyph_style <= glyph_style_next;
    end
  end

endmodule : text_cursor_control_engine
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Text cursor control engine testbench
// Streams character items through the cursor engine, mirrors the cursor and
// the register file in a local tracker, and checks every store action.
// ----------------------------------------------------------------------------
// The run starts with a short scripted sequence: characters whose store
// action is typed in by hand right after reset, then tab, saturation, wrap
// and deleted-code corner cases that are checked against the tracker. After
// that come randomized phases. Each phase waits for the block to go idle,
// loads a fresh register setting and streams random characters. The sender
// works in bursts with random gaps and the receiver stalls in patterns of its
// own, so back pressure lands on both the input register and the result register.
// ----------------------------------------------------------------------------
module testbench;
  import tcce_pkg::*;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  // Extra cycles after the owed actions return, to settle any leftovers.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int CYCLE_LIMIT   = 200000;

  localparam int PHASE_COUNT      = 10;
  localparam int ITEMS_PER_PHASE  = 75;

  // Register index that the block has no register behind.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  // Deleted code after reset, and the printable ASCII range.
  localparam logic [CodeW-1:0] DEL_RESET = 8'h7F;
  localparam logic [CodeW-1:0] PRINT_LO  = 8'h20;
  localparam logic [CodeW-1:0] PRINT_HI  = 8'h7E;

  // One store action as the block reports it.
  typedef struct packed {
    action_t         act;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic [7:0]      code;
    logic [7:0]      style;
  } store_op_t;

  // One line of the scripted sequence: a register write or a character.
  // When hand_typed is set, the action in want is used as typed, otherwise
  // the tracker supplies it.
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [7:0]          code;
    logic [7:0]          style;
    logic                hand_typed;
    store_op_t           want;
  } script_line_t;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_EVERY3,
    SINK_STARVED
  } sink_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CodeW-1:0]    char_code = '0;
  logic [CodeW-1:0]    char_style = '0;
  logic                out_ready = 1'b0;
  logic                out_valid;
  logic [1:0]          action;
  logic [PosW-1:0]     cell_col;
  logic [PosW-1:0]     cell_row;
  logic [CodeW-1:0]    glyph_code;
  logic [CodeW-1:0]    glyph_style;

  // Mirror of the register file, written alongside every register write.
  logic [6:0]          win_cols = 7'd64;
  logic                wrap_en = 1'b1;
  logic                htab_en = 1'b0;
  logic                vtab_en = 1'b0;
  logic [63:0]         h_stops = '0;
  logic [63:0]         v_stops = '0;
  logic [7:0]          del_code = DEL_RESET;

  // Tracked cursor position.
  logic [PosW-1:0]     cur_col = '0;
  logic [PosW-1:0]     cur_row = '0;

  // Store actions owed by the block, oldest first.
  store_op_t           pending_ops[$];
  script_line_t        script[$];

  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  int                  burst_left = 0;
  sink_mode_t          sink_mode = SINK_OPEN;
  int                  sink_left = 0;
  int                  sink_tick = 0;

  text_cursor_control_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .char_style  (char_style),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .action      (action),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .glyph_code  (glyph_code),
    .glyph_style (glyph_style)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cursor tracker
  // ---------------------------------------------------------------------------

  // A row step saturates on the last row instead of scrolling.
  function automatic void step_row();
    if (cur_row + 1 < MAX_ROWS) begin
      cur_row = cur_row + 1'b1;
    end
  endfunction

  // Lowest set stop strictly above pos and below limit, or -1 if none.
  // Walking down from the top leaves the lowest hit in place.
  function automatic int next_stop(input logic [63:0] stops, input int pos,
                                   input int limit);
    int hit;
    hit = -1;
    for (int k = limit - 1; k > pos; k--) begin
      if (stops[k]) begin
        hit = k;
      end
    end
    return hit;
  endfunction

  // Applies one character to the tracked cursor and returns the store action
  // that the block owes for it. Control codes are decoded ahead of the
  // deleted code, so a deleted code equal to a control acts as the control.
  function automatic store_op_t advance_cursor(input logic [7:0] code,
                                               input logic [7:0] style);
    store_op_t op;
    int        hit;
    int        lim;
    int        nxt;
    op = '0;
    op.act = ACT_NONE;
    if (code == CODE_LF) begin
      cur_col = '0;
      step_row();
    end else if (code == CODE_HT) begin
      if (htab_en) begin
        hit = next_stop(h_stops, int'(cur_col), MAX_COLS);
        if (hit >= 0) begin
          cur_col = hit[PosW-1:0];
        end else begin
          // No stop to the right: the tab falls back to a line feed.
          cur_col = '0;
          step_row();
        end
      end
    end else if (code == CODE_CR) begin
      cur_col = '0;
    end else if (code == CODE_FF) begin
      cur_col = '0;
      cur_row = '0;
      op.act = ACT_CLEAR;
    end else if (code == CODE_VT) begin
      if (vtab_en) begin
        hit = next_stop(v_stops, int'(cur_row), MAX_ROWS);
        if (hit >= 0) begin
          cur_row = hit[PosW-1:0];
        end
      end
    end else if (code == CODE_BS) begin
      if (cur_col != 0) begin
        cur_col = cur_col - 1'b1;
      end
      op.act = ACT_DELETE;
      op.col = cur_col;
      op.row = cur_row;
    end else if (code != del_code) begin
      // Oversized windows act as the full width; a zero-width window always
      // wraps when wrapping is on.
      lim = (win_cols > MAX_COLS) ? MAX_COLS : int'(win_cols);
      nxt = int'(cur_col) + 1;
      op.act = ACT_PLACE;
      op.col = cur_col;
      op.row = cur_row;
      op.code = code;
      op.style = style;
      if (wrap_en && nxt >= lim) begin
        cur_col = '0;
        step_row();
      end else if (nxt >= MAX_COLS) begin
        cur_col = PosW'(MAX_COLS - 1);
      end else begin
        cur_col = nxt[PosW-1:0];
      end
    end
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Script building
  // ---------------------------------------------------------------------------

  function automatic void add_cfg(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] data);
    script_line_t line;
    line = '0;
    line.is_cfg = 1'b1;
    line.idx = idx;
    line.data = data;
    script.push_back(line);
  endfunction

  function automatic void add_char(input logic [7:0] code, input logic [7:0] style);
    script_line_t line;
    line = '0;
    line.code = code;
    line.style = style;
    script.push_back(line);
  endfunction

  function automatic void add_typed(input logic [7:0] code, input logic [7:0] style,
                                    input action_t act, input int col, input int row,
                                    input logic [7:0] gcode, input logic [7:0] gstyle);
    script_line_t line;
    line = '0;
    line.code = code;
    line.style = style;
    line.hand_typed = 1'b1;
    line.want.act = act;
    line.want.col = col[PosW-1:0];
    line.want.row = row[PosW-1:0];
    line.want.code = gcode;
    line.want.style = gstyle;
    script.push_back(line);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Holds a register write until the block takes it and updates the mirror.
  // Valid is left high here; the next character or the next drain lowers it,
  // so back-to-back writes never drop and raise valid in the same step.
  task automatic set_register(input logic [CfgIdxW-1:0] idx,
                              input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_COLUMNS_IN_WINDOW: win_cols = data[6:0];
      REG_WRAP_ON:           wrap_en = data[0];
      REG_H_TABS_ON:         htab_en = data[0];
      REG_V_TABS_ON:         vtab_en = data[0];
      REG_H_TAB_STOPS:       h_stops = data;
      REG_V_TAB_STOPS:       v_stops = data;
      REG_DELETED_CODE:      del_code = data[7:0];
      default: ;
    endcase
  endtask

  // Offers one character item, in bursts of random length separated by
  // random gaps; about a quarter of the bursts follow with no gap at all.
  task automatic push_char(input logic [7:0] code, input logic [7:0] style,
                           input logic hand_typed, input store_op_t want);
    store_op_t model_op;
    int        gap;
    gap = 0;
    cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
      end
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= code;
    char_style <= style;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_op = advance_cursor(code, style);
    pending_ops.push_back(hand_typed ? want : model_op);
  endtask

  // Waits until every owed action has come back and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random settings and characters
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] pick_stops();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return {$urandom, $urandom};
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  task automatic pick_settings();
    logic [6:0] cols;
    logic [7:0] dcode;
    case ($urandom_range(0, 7))
      0:       cols = 7'd0;
      1:       cols = 7'd1;
      2:       cols = 7'd64;
      3:       cols = 7'd127;
      4:       cols = 7'($urandom_range(65, 126));
      5:       cols = 7'($urandom_range(17, 63));
      default: cols = 7'($urandom_range(2, 16));
    endcase
    case ($urandom_range(0, 4))
      0:       dcode = DEL_RESET;
      1:       dcode = 8'h00;
      2:       dcode = 8'hFF;
      3:       dcode = 8'($urandom_range(CODE_BS, CODE_CR));
      default: dcode = 8'($urandom_range(0, 255));
    endcase
    set_register(REG_COLUMNS_IN_WINDOW, {57'd0, cols});
    set_register(REG_WRAP_ON, {$urandom, $urandom});
    set_register(REG_H_TABS_ON, {63'd0, $urandom_range(0, 3) != 0});
    set_register(REG_V_TABS_ON, {63'd0, $urandom_range(0, 3) != 0});
    set_register(REG_H_TAB_STOPS, pick_stops());
    set_register(REG_V_TAB_STOPS, pick_stops());
    set_register(REG_DELETED_CODE, {56'd0, dcode});
    if ($urandom_range(0, 3) == 0) begin
      set_register(REG_UNUSED, {$urandom, $urandom});
    end
  endtask

  // Mostly arbitrary bytes and printable text, with a steady share of cursor
  // controls so rows climb toward saturation; form feeds stay rare.
  function automatic logic [7:0] pick_code();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll <= 10) begin
      return 8'($urandom_range(0, 255));
    end else if (roll <= 13) begin
      return 8'($urandom_range(PRINT_LO, PRINT_HI));
    end else if (roll <= 18) begin
      case ($urandom_range(0, 10))
        0, 1, 2: return CODE_LF;
        3:       return CODE_CR;
        4, 5:    return CODE_BS;
        6, 7:    return CODE_HT;
        8, 9:    return CODE_VT;
        default: return CODE_FF;
      endcase
    end else begin
      return del_code;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Every accepted action is matched against the oldest one owed. The ready
  // pattern switches between open, coin-flip, one-in-three and starved modes.
  always @(posedge clk) begin : store_sink
    store_op_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_ops.size() == 0) begin
        $display("%0t: unexpected action %0d at col %0d row %0d", $time, action,
                 cell_col, cell_row);
        mismatch_count++;
      end else begin
        want = pending_ops.pop_front();
        check_field("action", 64'(want.act), 64'(action));
        check_field("cell_col", 64'(want.col), 64'(cell_col));
        check_field("cell_row", 64'(want.row), 64'(cell_row));
        check_field("glyph_code", 64'(want.code), 64'(glyph_code));
        check_field("glyph_style", 64'(want.style), 64'(glyph_style));
      end
    end
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(10, 80);
    end else begin
      sink_left--;
    end
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:   out_ready <= 1'b1;
      SINK_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      SINK_EVERY3: out_ready <= (sink_tick % 3 == 0);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[text_cursor_control_engine] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    script_line_t line;

    // Right after reset: placements at the byte extremes, the reset deleted
    // code, backspace including the stop at column 0, disabled tabs, line
    // feed and form feed. These actions are typed in by hand.
    add_typed(8'h41, 8'hFF, ACT_PLACE, 0, 0, 8'h41, 8'hFF);
    add_typed(8'h00, 8'h00, ACT_PLACE, 1, 0, 8'h00, 8'h00);
    add_typed(8'hFF, 8'hA5, ACT_PLACE, 2, 0, 8'hFF, 8'hA5);
    add_typed(DEL_RESET, 8'h3C, ACT_NONE, 0, 0, 8'h00, 8'h00);
    add_typed(CODE_BS, 8'h11, ACT_DELETE, 2, 0, 8'h00, 8'h00);
    add_typed(CODE_CR, 8'h22, ACT_NONE, 0, 0, 8'h00, 8'h00);
    add_typed(CODE_BS, 8'h44, ACT_DELETE, 0, 0, 8'h00, 8'h00);
    add_typed(CODE_HT, 8'h55, ACT_NONE, 0, 0, 8'h00, 8'h00);
    add_typed(CODE_VT, 8'h66, ACT_NONE, 0, 0, 8'h00, 8'h00);
    add_typed(CODE_LF, 8'h77, ACT_NONE, 0, 0, 8'h00, 8'h00);
    add_typed(8'h78, 8'h0F, ACT_PLACE, 0, 1, 8'h78, 8'h0F);
    add_typed(CODE_FF, 8'h88, ACT_CLEAR, 0, 0, 8'h00, 8'h00);

    // Tab stops at column 5 and the last column, and on the last row only.
    // Three tabs reach both stops and then fall back to a line feed; the
    // vertical tab jumps to the last row, where a line feed saturates.
    add_cfg(REG_H_TABS_ON, 64'd1);
    add_cfg(REG_H_TAB_STOPS, 64'h8000_0000_0000_0020);
    add_cfg(REG_V_TABS_ON, 64'd1);
    add_cfg(REG_V_TAB_STOPS, 64'h8000_0000_0000_0000);
    add_char(CODE_HT, 8'h01);
    add_char(CODE_HT, 8'h02);
    add_char(CODE_HT, 8'h04);
    add_char(CODE_VT, 8'h08);
    add_char(CODE_LF, 8'h10);

    // Without wrap, placing at the right edge pins the column there.
    add_cfg(REG_WRAP_ON, 64'd0);
    add_char(CODE_HT, 8'h20);
    add_char(CODE_HT, 8'h40);
    add_char(8'h5A, 8'hC3);
    add_char(8'h5A, 8'h3C);

    // A zero-width window wraps on every placement; here it also hits the
    // row saturation in the bottom-right corner.
    add_cfg(REG_WRAP_ON, 64'd1);
    add_cfg(REG_COLUMNS_IN_WINDOW, 64'd0);
    add_char(8'h71, 8'h96);

    // Oversized window, a deleted code equal to line feed (the control wins),
    // and a write to an index with no register behind it.
    add_cfg(REG_COLUMNS_IN_WINDOW, 64'd100);
    add_cfg(REG_DELETED_CODE, {56'd0, CODE_LF});
    add_cfg(REG_UNUSED, '1);
    add_char(CODE_LF, 8'h69);
    add_char(DEL_RESET, 8'h5A);
    add_char(8'h77, 8'hF0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (script.size() != 0) begin
      line = script.pop_front();
      if (line.is_cfg) begin
        drain();
        set_register(line.idx, line.data);
      end else begin
        push_char(line.code, line.style, line.hand_typed, line.want);
      end
    end

    // Random phases, each under a fresh register setting.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain();
      pick_settings();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_char(pick_code(), 8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[text_cursor_control_engine] OK");
    end else begin
      $display("[text_cursor_control_engine] ERROR");
    end
    $finish;
  end

endmodule

@@ text_cursor_control_engine.f @@
rtl/tcce_pkg.sv
rtl/tcce_next_stop.sv
rtl/text_cursor_control_engine.sv
tb/testbench.sv
